>>> sv/ultrasonic_echo_zone_ranger_assert.svh
// ----------------------------------------------------------------------------
// ultrasonic echo zone ranger assertion macros
// implication checks on the rising clock edge, removed when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_ZONE_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_ZONE_RANGER_ASSERT_SVH
`ifndef ASSERT_OFF
`define UEZR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define UEZR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define UEZR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UEZR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/uezr_pkg.sv
// ----------------------------------------------------------------------------
// uezr_pkg
// shared widths, constants, register indexes and control types of the ranger
// ----------------------------------------------------------------------------
`default_nettype none

package uezr_pkg;

    localparam int IN_W       = 16;
    localparam int DIST_W     = 9;
    localparam int OFFSET_W   = 10;
    localparam int PITCH_W    = 8;
    localparam int KEY_W      = 6;
    localparam int ZONE_W     = 3;
    localparam int TOP_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int SMOOTH_DEPTH_DEF = 3;
    localparam int MAX_RANGE_MM     = 500;
    localparam int ZONE_COUNT       = 6;

    localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(80);
    localparam logic [PITCH_W-1:0]  PITCH_RST  = PITCH_W'(20);

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PITCH  = CFG_IDX_W'(1);

    // 0.1715 mm/us as 11239 / 2^16
    localparam int                    MM_SCALE_W = 14;
    localparam logic [MM_SCALE_W-1:0] MM_SCALE   = MM_SCALE_W'(11239);
    localparam int                    DIGIT_W    = 2;
    localparam int                    ADD_W      = MM_SCALE_W + DIGIT_W;
    localparam int                    MUL_STEPS  = IN_W / DIGIT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RING,
        ST_MEAN_GO,
        ST_MEAN,
        ST_WIN,
        ST_ZONE,
        ST_OUT
    } uezr_state_t;

    function automatic logic [ADD_W-1:0] mm_addend(input logic [DIGIT_W-1:0] digit);
        logic [ADD_W-1:0] scale;
        scale = ADD_W'(MM_SCALE);
        unique case (digit)
            2'd0:    mm_addend = '0;
            2'd1:    mm_addend = scale;
            2'd2:    mm_addend = scale << 1;
            2'd3:    mm_addend = (scale << 1) + scale;
            default: mm_addend = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> sv/ultrasonic_echo_zone_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_zone_ranger
// echo width to mm, ring mean, window check and zone / key decode
//
//   channel  dir  handshake         payload
//   s_       in   s_valid/s_ready   s_echo_width_us
//   m_       out  m_valid/m_ready   m_smoothed_mm, m_key_bits, m_zone
//   cfg_     in   cfg_wr_en         cfg_index, cfg_wdata
//
// each beat takes eight radix-4 multiply steps, then two passes through the
// shared bit-serial divider (ring sum by depth, then offset distance by pitch).
// reset clears the ring, its running sum and the slot pointer at once.
// a new beat is taken while a result waits; a stalled result holds only the
// final output load.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ultrasonic_echo_zone_ranger_assert.svh"

module ultrasonic_echo_zone_ranger
    import uezr_pkg::*;
#(
    parameter int SMOOTH_DEPTH = SMOOTH_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [IN_W-1:0]       s_echo_width_us,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DIST_W-1:0]          m_smoothed_mm,
    output logic [KEY_W-1:0]           m_key_bits,
    output logic [ZONE_W-1:0]          m_zone,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SLOT_W = $clog2(SMOOTH_DEPTH);
    localparam int SUM_W  = DIST_W + $clog2(SMOOTH_DEPTH);

    uezr_state_t state_reg, state_next;

    logic [OFFSET_W-1:0] offset_reg;
    logic [PITCH_W-1:0]  pitch_reg;

    logic [DIST_W-1:0]   ring_reg [SMOOTH_DEPTH];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic [DIST_W-1:0]   mean_reg;
    logic [DIST_W-1:0]   win_mean_reg;
    logic                ok_reg;
    logic [SUM_W-1:0]    q_reg;

    logic                m_valid_reg;
    logic [DIST_W-1:0]   smoothed_reg;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [ZONE_W-1:0]   zone_reg, zone_next;

    logic                accept;
    logic                mul_done;
    logic [IN_W-1:0]     mul_hi;
    logic [DIST_W-1:0]   dist_mm;

    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic [PITCH_W-1:0]  div_divisor;
    logic                div_done;
    logic [SUM_W-1:0]    div_quotient;

    logic [TOP_W-1:0]    top_mm;
    logic                in_win;
    logic [DIST_W-1:0]   win_mean;
    logic                ge_off;
    logic [OFFSET_W-1:0] off_diff;

    logic                ring_wr;
    logic                mean_ld;
    logic                win_ld;
    logic                q_ld;
    logic                out_ld;

    assign accept = s_valid && s_ready;

    uezr_mul u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .width_us   (s_echo_width_us),
        .done       (mul_done),
        .product_hi (mul_hi)
    );

    assign dist_mm = (mul_hi > IN_W'(MAX_RANGE_MM)) ? '0 : mul_hi[DIST_W-1:0];

    uezr_div #(
        .DVD_W (SUM_W),
        .DVS_W (PITCH_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // window and offset distance of the ring mean
    assign top_mm   = TOP_W'(offset_reg) + TOP_W'(pitch_reg) * TOP_W'(ZONE_COUNT);
    assign in_win   = (OFFSET_W'(mean_reg) >= offset_reg) &&
                      (TOP_W'(mean_reg) <= top_mm);
    assign win_mean = in_win ? mean_reg : '0;
    assign ge_off   = OFFSET_W'(win_mean) >= offset_reg;
    assign off_diff = OFFSET_W'(win_mean) - offset_reg;

    assign div_dividend = (state_reg == ST_WIN) ? SUM_W'(off_diff[DIST_W-1:0]) : sum_reg;
    assign div_divisor  = (state_reg == ST_WIN) ? pitch_reg : PITCH_W'(SMOOTH_DEPTH);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_MUL;
            ST_MUL:     if (mul_done) state_next = ST_RING;
            ST_RING:    state_next = ST_MEAN_GO;
            ST_MEAN_GO: state_next = ST_MEAN;
            ST_MEAN:    if (div_done) state_next = ST_WIN;
            ST_WIN:     state_next = ST_ZONE;
            ST_ZONE:    if (div_done) state_next = ST_OUT;
            ST_OUT:     if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        ring_wr   = 1'b0;
        div_start = 1'b0;
        mean_ld   = 1'b0;
        win_ld    = 1'b0;
        q_ld      = 1'b0;
        out_ld    = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_MUL:     ;
            ST_RING:    ring_wr = 1'b1;
            ST_MEAN_GO: div_start = 1'b1;
            ST_MEAN:    mean_ld = div_done;
            ST_WIN: begin
                div_start = 1'b1;
                win_ld    = 1'b1;
            end
            ST_ZONE:    q_ld = div_done;
            ST_OUT:     out_ld = !m_valid_reg || m_ready;
            default:    ;
        endcase
    end

    always_comb begin
        zone_next = '0;
        if (ok_reg && (q_reg < SUM_W'(ZONE_COUNT))) begin
            zone_next = ZONE_W'(q_reg + SUM_W'(1));
        end
        for (int z = 0; z < KEY_W; z++) begin
            key_next[z] = ok_reg && ((q_reg == SUM_W'(z)) || (q_reg == SUM_W'(z + 1)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            offset_reg  <= OFFSET_RST;
            pitch_reg   <= PITCH_RST;
            slot_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SMOOTH_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_OFFSET: offset_reg <= cfg_wdata[OFFSET_W-1:0];
                    REG_PITCH:  pitch_reg  <= cfg_wdata[PITCH_W-1:0];
                    default:    ;
                endcase
            end
            if (ring_wr) begin
                ring_reg[slot_reg] <= dist_mm;
                sum_reg  <= sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(dist_mm);
                slot_reg <= (slot_reg == SLOT_W'(SMOOTH_DEPTH - 1)) ? '0
                                                                     : slot_reg + SLOT_W'(1);
            end
            priority if (out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (mean_ld) begin
            mean_reg <= div_quotient[DIST_W-1:0];
        end
        if (win_ld) begin
            win_mean_reg <= win_mean;
            ok_reg       <= ge_off && (pitch_reg != '0);
        end
        if (q_ld) begin
            q_reg <= div_quotient;
        end
        if (out_ld) begin
            smoothed_reg <= win_mean_reg;
            key_reg      <= key_next;
            zone_reg     <= zone_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_smoothed_mm = smoothed_reg;
    assign m_key_bits    = key_reg;
    assign m_zone        = zone_reg;

    `UEZR_ASSERT_NXT(a_accept_starts_mul, aclk, aresetn, accept, state_reg == ST_MUL)
    `UEZR_ASSERT_IMP(a_result_from_out, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_OUT)
    `UEZR_ASSERT_IMP(a_zone_has_key, aclk, aresetn, m_valid && (m_zone != '0), m_key_bits[m_zone - 3'd1])
    `UEZR_ASSERT_IMP(a_slot_in_ring, aclk, aresetn, 1'b1, slot_reg <= SLOT_W'(SMOOTH_DEPTH - 1))

endmodule

`default_nettype wire

>>> sv/uezr_mul.sv
// ----------------------------------------------------------------------------
// uezr_mul
// radix-4 serial multiply of the echo width by the mm scale, high half kept
// ----------------------------------------------------------------------------
`default_nettype none

module uezr_mul
    import uezr_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [IN_W-1:0] width_us,
    output logic                 done,
    output logic [IN_W-1:0]      product_hi
);

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IN_W-1:0]  hi_reg, hi_next;
    logic [IN_W-1:0]  lo_reg, lo_next;
    logic [ADD_W:0]   acc_sum;

    assign acc_sum = {1'b0, hi_reg} + {1'b0, mm_addend(lo_reg[DIGIT_W-1:0])};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MUL_STEPS - 1);
            hi_next   = '0;
            lo_next   = width_us;
        end else if (busy_reg) begin
            // shift the product down one digit while the multiplier shifts out
            hi_next  = IN_W'(acc_sum[ADD_W:DIGIT_W]);
            lo_next  = {acc_sum[DIGIT_W-1:0], lo_reg[IN_W-1:DIGIT_W]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done       = done_reg;
    assign product_hi = hi_reg;

endmodule

`default_nettype wire

>>> sv/uezr_div.sv
// ----------------------------------------------------------------------------
// uezr_div
// restoring divider, one quotient bit per cycle, shared by mean and zone
// ----------------------------------------------------------------------------
`default_nettype none

module uezr_div #(
    parameter int DVD_W = 11,
    parameter int DVS_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             trial_ge;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign trial_ge  = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], trial_ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> tb/sv/echo_range_checker.sv
// ----------------------------------------------------------------------------
// echo range checker
// watches the echo and result channels and the register port, predicts the
// smoothed distance, key bitmap and zone of every accepted echo beat and
// compares each result beat against the oldest prediction
// ----------------------------------------------------------------------------
module echo_range_checker
    import uezr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [IN_W-1:0]       s_echo_width_us,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [DIST_W-1:0]     m_smoothed_mm,
    input  logic [KEY_W-1:0]      m_key_bits,
    input  logic [ZONE_W-1:0]     m_zone,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIST_W-1:0] smoothed_mm;
        logic [KEY_W-1:0]  key_bits;
        logic [ZONE_W-1:0] zone;
    } range_result_t;

    logic [OFFSET_W-1:0] offset_mm;
    logic [PITCH_W-1:0]  pitch_mm;
    logic [DIST_W-1:0]   ring_mm [SMOOTH_DEPTH_DEF];
    int unsigned         ring_slot;
    range_result_t       expected_ranges [$];

    function automatic logic [KEY_W-1:0] zone_key(input int unsigned dist_mm,
                                                  input int unsigned origin_mm,
                                                  input int unsigned step_mm);
        int unsigned idx;
        zone_key = '0;
        if (dist_mm >= origin_mm && step_mm != 0) begin
            idx = (dist_mm - origin_mm) / step_mm;
            if (idx < ZONE_COUNT)
                zone_key[idx] = 1'b1;
        end
    endfunction

    // advances the ring and returns the decoded result of one echo
    function automatic range_result_t predict_range(input logic [IN_W-1:0] width_us);
        int unsigned   dist_mm;
        int unsigned   sum_mm;
        int unsigned   mean_mm;
        int unsigned   top_mm;
        int unsigned   org_mm;
        int unsigned   step_mm;
        int unsigned   idx;
        range_result_t r;
        org_mm  = offset_mm;
        step_mm = pitch_mm;
        dist_mm = (32'(width_us) * 32'(MM_SCALE)) >> 16;
        if (dist_mm > MAX_RANGE_MM)
            dist_mm = 0;
        ring_mm[ring_slot] = dist_mm[DIST_W-1:0];
        ring_slot = (ring_slot + 1) % SMOOTH_DEPTH_DEF;
        sum_mm = 0;
        for (int i = 0; i < SMOOTH_DEPTH_DEF; i++)
            sum_mm += ring_mm[i];
        mean_mm = sum_mm / SMOOTH_DEPTH_DEF;
        top_mm = org_mm + ZONE_COUNT * step_mm;
        if (mean_mm < org_mm || mean_mm > top_mm)
            mean_mm = 0;
        r = '0;
        r.smoothed_mm = mean_mm[DIST_W-1:0];
        if (step_mm != 0) begin
            r.key_bits = zone_key(mean_mm, org_mm, step_mm) |
                         zone_key(mean_mm, org_mm + step_mm, step_mm);
            if (mean_mm >= org_mm) begin
                idx = (mean_mm - org_mm) / step_mm;
                if (idx < ZONE_COUNT)
                    r.zone = ZONE_W'(idx + 1);
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        range_result_t want;
        if (!aresetn) begin
            offset_mm = OFFSET_RST;
            pitch_mm  = PITCH_RST;
            for (int i = 0; i < SMOOTH_DEPTH_DEF; i++)
                ring_mm[i] = '0;
            ring_slot = 0;
            expected_ranges.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_OFFSET)
                    offset_mm = cfg_wdata[OFFSET_W-1:0];
                else if (cfg_index == REG_PITCH)
                    pitch_mm = cfg_wdata[PITCH_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (expected_ranges.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result beat with none expected: mm %0d keys %b zone %0d",
                                 $time, m_smoothed_mm, m_key_bits, m_zone);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_ranges.pop_front();
                    if (m_smoothed_mm !== want.smoothed_mm || m_key_bits !== want.key_bits ||
                        m_zone !== want.zone) begin
                        if (fail_count < 10)
                            $display("%0t: result beat differs: mm %0d/%0d keys %b/%b zone %0d/%0d",
                                     $time, want.smoothed_mm, m_smoothed_mm, want.key_bits,
                                     m_key_bits, want.zone, m_zone);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_ranges.push_back(predict_range(s_echo_width_us));
        end
        pending_count <= expected_ranges.size();
    end

endmodule

>>> tb/sv/ultrasonic_echo_zone_ranger_test.sv
// ----------------------------------------------------------------------------
// ultrasonic echo zone ranger testbench
// drives directed edge cases and grouped random echo widths through several
// offset and pitch settings with random idling on both channels, a long
// result stall and full drains between settings; the checker judges results
// ----------------------------------------------------------------------------
module ultrasonic_echo_zone_ranger_test;
    timeunit 1ns;
    timeprecision 1ps;
    import uezr_pkg::*;

    localparam int HOLD_CYCLES = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_W-1:0]       s_echo_width_us;
    logic                  m_valid;
    logic                  m_ready;
    logic [DIST_W-1:0]     m_smoothed_mm;
    logic [KEY_W-1:0]      m_key_bits;
    logic [ZONE_W-1:0]     m_zone;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          range_fails;
    int          pending_ranges;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned cur_offset = OFFSET_RST;
    int unsigned cur_pitch = PITCH_RST;

    ultrasonic_echo_zone_ranger DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_echo_width_us (s_echo_width_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smoothed_mm   (m_smoothed_mm),
        .m_key_bits      (m_key_bits),
        .m_zone          (m_zone),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    echo_range_checker range_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_echo_width_us (s_echo_width_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smoothed_mm   (m_smoothed_mm),
        .m_key_bits      (m_key_bits),
        .m_zone          (m_zone),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (range_fails),
        .pending_count   (pending_ranges)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("ultrasonic_echo_zone_ranger: mismatch");
        $finish;
    end

    // result side: random stalls, or one long hold on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= !idle_en || ($urandom_range(99) >= 11);
            end
        end
    end

    task automatic send_beat(input logic [IN_W-1:0] width_us);
        s_echo_width_us <= width_us;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (idle_en && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_ranges != 0) @(posedge aclk);
    endtask

    task automatic write_config(input logic [OFFSET_W-1:0] offset,
                                input logic [CFG_DATA_W-1:0] pitch_word);
        cfg_index <= REG_OFFSET;
        cfg_wdata <= CFG_DATA_W'(offset);
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_index <= REG_PITCH;
        cfg_wdata <= pitch_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_offset = offset;
        cur_pitch = pitch_word[PITCH_W-1:0];
    endtask

    // three beats: one ring's worth aimed at the window, or noise
    task automatic send_group();
        int unsigned kind;
        int unsigned span;
        int unsigned target;
        int unsigned base;
        bit          exact;
        kind = $urandom_range(99);
        span = ZONE_COUNT * cur_pitch;
        base = $urandom_range(0, 2960);
        exact = 1'b0;
        case ($urandom_range(3))
            0: begin
                target = cur_offset;
                exact = 1'b1;
            end
            1: begin
                target = cur_offset + span;
                exact = 1'b1;
            end
            default: target = cur_offset + $urandom_range(0, span);
        endcase
        for (int k = 0; k < 3; k++) begin
            if (kind < 55)
                send_beat(IN_W'((target * 65536 + 11238) / 11239 +
                                (exact ? 0 : $urandom_range(0, 5))));
            else if (kind < 75)
                send_beat(IN_W'($urandom_range(0, 2960)));
            else if (kind < 88)
                send_beat(IN_W'($urandom_range(0, 65535)));
            else
                send_beat(IN_W'(base));
        end
    endtask

    task automatic run_phase(input logic [OFFSET_W-1:0] offset,
                             input logic [CFG_DATA_W-1:0] pitch_word,
                             input int groups, input bit hold);
        drain_results();
        write_config(offset, pitch_word);
        if (hold)
            hold_req = 1'b1;
        repeat (groups) send_group();
    endtask

    initial begin
        logic [IN_W-1:0] edge_widths [$];
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_echo_width_us <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_OFFSET;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, range cutoff, window edges and zone boundary at reset settings
        edge_widths = '{16'd0, 16'hFFFF, 16'h8000, 16'd1, 16'd2922, 16'd2923,
                        16'h5555, 16'hAAAA,
                        16'd467, 16'd467, 16'd467, 16'd461, 16'd461, 16'd461,
                        16'd1167, 16'd1167, 16'd1167, 16'd1173, 16'd1173, 16'd1173,
                        16'd583, 16'd584, 16'd584};
        foreach (edge_widths[i])
            send_beat(edge_widths[i]);

        run_phase(OFFSET_RST, CFG_DATA_W'(PITCH_RST), 30, 1'b1);
        run_phase(10'd0, 10'd1, 25, 1'b0);
        run_phase(10'd1023, 10'h3FF, 12, 1'b0);
        run_phase(10'd0, 10'd255, 20, 1'b0);
        run_phase(10'd500, 10'h300, 15, 1'b0);
        idle_en = 1'b0;
        run_phase(10'd150, 10'd40, 30, 1'b0);
        idle_en = 1'b1;
        repeat (5)
            run_phase(OFFSET_W'($urandom_range(0, 400)),
                      {2'($urandom_range(0, 3)), 8'($urandom_range(1, 80))}, 30, 1'b0);

        drain_results();
        repeat (60) @(posedge aclk);
        if (range_fails == 0)
            $display("ultrasonic_echo_zone_ranger: match");
        else
            $display("ultrasonic_echo_zone_ranger: mismatch");
        $finish;
    end

endmodule
